// File: hw/rtl/histogram_equalizer_defines.svh
// assertion macros used by the checker file
`ifndef HISTOGRAM_EQUALIZER_DEFINES_SVH
`define HISTOGRAM_EQUALIZER_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define HQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define HQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/histeq_pkg.sv
`default_nettype none
package histeq_pkg;

  localparam int CNT_W        = 25;
  localparam int REG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int LEVELS_DEF   = 256;
  localparam int MAX_SIDE_DEF = 4096;
  localparam int SIDE_RESET   = 256;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    ACT_COUNT    = 2'd0,
    ACT_FINALIZE = 2'd1,
    ACT_MAP      = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  localparam logic KIND_MAP = 1'b0;
  localparam logic KIND_FIN = 1'b1;

endpackage
`default_nettype wire

// File: hw/rtl/histeq_div.sv
`default_nettype none
// restoring divider, 8 quotient bits, one per cycle; quotient saturates at 255
module histeq_div #(
  parameter int NW = 35,
  parameter int DW = 27
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [7:0]         quot
);

  localparam int CW = (NW > DW + 8) ? NW : DW + 8;

  logic [CW-1:0] rem_r;
  logic [CW-1:0] dsh_r;
  logic [2:0]    step_r;
  logic          busy_r;
  logic [7:0]    q_r;
  logic [CW-1:0] num_w;
  logic [CW-1:0] den_w;

  assign num_w = CW'(num);
  assign den_w = CW'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      rem_r  <= num_w;
      dsh_r  <= den_w << 7;
      step_r <= '0;
      if (num_w >= (den_w << 8)) begin
        q_r    <= 8'hFF;
        busy_r <= 1'b0;
      end else begin
        q_r    <= '0;
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[6:0], 1'b1};
      end else begin
        q_r <= {q_r[6:0], 1'b0};
      end
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r + 3'd1;
      if (step_r == 3'd7) busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// File: hw/rtl/histogram_equalizer.sv
`default_nettype none
// one item at a time; in_ready is high only while idle
// count: table read, then write back; clear: no result
// map: read, subtract, multiply, 8-step divider, then the output register once the slot frees
// finalize: one table entry read and written per cycle
// reset (synchronous, active low) clears the table at once through per-entry valid bits
module histogram_equalizer #(
  parameter int LEVELS   = histeq_pkg::LEVELS_DEF,
  parameter int MAX_SIDE = histeq_pkg::MAX_SIDE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       in_action,
  input  wire logic [7:0]                       in_pixel_value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_result_kind,
  output logic [7:0]                            out_pixel,
  output logic [histeq_pkg::CNT_W-1:0]          out_lowest_count,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [histeq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [histeq_pkg::REG_W-1:0]     cfg_data
);

  localparam int CW  = histeq_pkg::CNT_W;
  localparam int RW  = histeq_pkg::REG_W;
  localparam int LB  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW  = CW + LB;
  localparam int NW  = PW + 2;
  localparam int AW  = 2 * RW;
  localparam int QMAX = (LEVELS - 1 < 255) ? LEVELS - 1 : 255;
  localparam logic [LB-1:0] LTOP = LB'(LEVELS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DATA, S_MUL, S_DIV, S_MOUT, S_FIN, S_FOUT
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     mem [LEVELS];
  logic [CW-1:0]     mem_q;
  logic [LEVELS-1:0] vld_r;
  logic              rd_vld_r;
  logic              mem_we;
  logic [LB-1:0]     mem_wa;
  logic [CW-1:0]     mem_wd;
  logic [LB-1:0]     mem_ra;
  logic [CW-1:0]     rd_val;

  logic [RW-1:0]     width_r;
  logic [RW-1:0]     height_r;
  logic [RW-1:0]     side_w;
  logic [RW-1:0]     side_h;
  logic [AW-1:0]     area_r;

  histeq_pkg::action_t act_r;
  logic [LB-1:0]     lvl_r;
  logic [LB-1:0]     in_lvl;
  logic [CW-1:0]     lowest_r;
  logic [CW-1:0]     diff_r;
  logic [PW-1:0]     prod_r;
  logic              div_start_r;
  logic              div_busy;
  logic [7:0]        div_q;
  logic [7:0]        q_clamp;

  logic [LB:0]       fin_cnt_r;
  logic [CW-1:0]     sum_r;
  logic [CW-1:0]     sum_nxt;
  logic [CW:0]       sum_wide;
  logic              found_r;
  logic              found_nxt;
  logic [CW-1:0]     low_r;
  logic [CW-1:0]     low_nxt;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [7:0]        out_pixel_r;
  logic [CW-1:0]     out_low_r;
  logic              slot_free;

  function automatic logic [RW-1:0] side_of(input logic [RW-1:0] v);
    logic [RW-1:0] s;
    if (v == '0) s = RW'(1);
    else if (32'(v) > MAX_SIDE) s = RW'(MAX_SIDE);
    else s = v;
    return s;
  endfunction

  assign side_w = side_of(width_r);
  assign side_h = side_of(height_r);

  assign in_lvl = (32'(in_pixel_value) > LEVELS - 1) ? LTOP : LB'(in_pixel_value);
  assign rd_val = rd_vld_r ? mem_q : '0;

  assign sum_wide = {1'b0, sum_r} + {1'b0, rd_val};
  assign sum_nxt  = sum_wide[CW] ? histeq_pkg::CNT_MAX : sum_wide[CW-1:0];
  assign found_nxt = found_r || (rd_val != '0);
  assign low_nxt   = found_r ? low_r : rd_val;

  assign q_clamp   = (32'(div_q) > QMAX) ? 8'(QMAX) : div_q;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = lvl_r;
    mem_wd = '0;
    mem_ra = (state_r == S_FIN) ? fin_cnt_r[LB-1:0] : in_lvl;
    if (state_r == S_DATA && act_r == histeq_pkg::ACT_COUNT) begin
      mem_we = 1'b1;
      mem_wd = (rd_val == histeq_pkg::CNT_MAX) ? rd_val : rd_val + CW'(1);
    end else if (state_r == S_FIN && fin_cnt_r != '0) begin
      mem_we = 1'b1;
      mem_wa = LB'(fin_cnt_r - 1'b1);
      mem_wd = sum_nxt;
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q    <= mem[mem_ra];
    rd_vld_r <= vld_r[mem_ra];
  end

  histeq_div #(.NW(NW), .DW(AW + 1)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   ({prod_r, 1'b0} + NW'(area_r)),
    .den   ({area_r, 1'b0}),
    .busy  (div_busy),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      lowest_r    <= '0;
      width_r     <= RW'(histeq_pkg::SIDE_RESET);
      height_r    <= RW'(histeq_pkg::SIDE_RESET);
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      fin_cnt_r   <= '0;
      found_r     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == histeq_pkg::REG_WIDTH) width_r <= cfg_data;
        else if (cfg_index == histeq_pkg::REG_HEIGHT) height_r <= cfg_data;
      end
      area_r      <= AW'(side_w) * AW'(side_h);
      div_start_r <= (state_r == S_MUL);
      // the result states load a new result themselves once the slot frees
      if (out_valid_r && out_ready && !(state_r inside {S_MOUT, S_FOUT}))
        out_valid_r <= 1'b0;
      if (mem_we) vld_r[mem_wa] <= 1'b1;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r <= histeq_pkg::action_t'(in_action);
            lvl_r <= in_lvl;
            case (histeq_pkg::action_t'(in_action))
              histeq_pkg::ACT_CLEAR: begin
                vld_r    <= '0;
                lowest_r <= '0;
              end
              histeq_pkg::ACT_FINALIZE: begin
                fin_cnt_r <= '0;
                sum_r     <= '0;
                found_r   <= 1'b0;
                low_r     <= '0;
                state_r   <= S_FIN;
              end
              default: state_r <= S_DATA;
            endcase
          end
        end
        S_DATA: begin
          if (act_r == histeq_pkg::ACT_COUNT) begin
            state_r <= S_IDLE;
          end else begin
            diff_r  <= (rd_val > lowest_r) ? rd_val - lowest_r : '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PW'(diff_r) * PW'(LEVELS - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!div_start_r && !div_busy) state_r <= S_MOUT;
        end
        S_MOUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= histeq_pkg::KIND_MAP;
            out_pixel_r <= q_clamp;
            out_low_r   <= '0;
            state_r     <= S_IDLE;
          end
        end
        S_FIN: begin
          // entry k is read while entry k-1 is summed and written back
          if (fin_cnt_r != '0) begin
            sum_r   <= sum_nxt;
            found_r <= found_nxt;
            low_r   <= low_nxt;
          end
          if (fin_cnt_r == (LB + 1)'(LEVELS)) begin
            lowest_r <= found_nxt ? low_nxt : '0;
            state_r  <= S_FOUT;
          end else begin
            fin_cnt_r <= fin_cnt_r + 1'b1;
          end
        end
        S_FOUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= histeq_pkg::KIND_FIN;
            out_pixel_r <= '0;
            out_low_r   <= lowest_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_pixel        = out_pixel_r;
  assign out_lowest_count = out_low_r;

endmodule
`default_nettype wire

// File: hw/rtl/histeq_chk.sv
`default_nettype none
`include "histogram_equalizer_defines.svh"
module histeq_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             out_result_kind,
  input wire logic [7:0]                       out_pixel,
  input wire logic [histeq_pkg::CNT_W-1:0]     out_lowest_count
);

  `HQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_lowest_count), "result changed while stalled")

  `HQ_ASSERT(a_kind_fields, clk, rst_n, out_valid |-> (out_result_kind == histeq_pkg::KIND_FIN ? out_pixel == 8'd0 : out_lowest_count == '0), "unused result field not zero")

  // no transaction produces a result in the cycle right after it is taken
  `HQ_ASSERT(a_no_instant, clk, rst_n, in_valid && in_ready |=> !$rose(out_valid), "result appeared too early")

  `HQ_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind histogram_equalizer histeq_chk u_histeq_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_kind  (out_result_kind),
  .out_pixel        (out_pixel),
  .out_lowest_count (out_lowest_count)
);
`default_nettype wire

// File: dv/tb_histogram_equalizer.sv
`default_nettype none
module tb_histogram_equalizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LEVELS = 256;
  localparam int SIDE_MAX   = 4096;
  localparam int ITEM_GOAL  = 1450;
  localparam int SETTLE     = 320;
  localparam int STALL_MAX  = 20000;

  typedef struct packed {
    histeq_pkg::action_t act;
    logic [7:0]          pix;
  } pixel_op_t;

  typedef struct packed {
    logic                        kind;
    logic [7:0]                  pix;
    logic [histeq_pkg::CNT_W-1:0] low;
  } eq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_action = '0;
  logic [7:0] in_pixel_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_result_kind;
  logic [7:0] out_pixel;
  logic [histeq_pkg::CNT_W-1:0] out_lowest_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [histeq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [histeq_pkg::REG_W-1:0] cfg_data = '0;

  pixel_op_t  op_q[$];
  eq_result_t result_q[$];
  logic [histeq_pkg::CNT_W-1:0] cdf_table[NUM_LEVELS];
  logic [histeq_pkg::CNT_W-1:0] first_cdf;
  logic [histeq_pkg::REG_W-1:0] img_w, img_h;
  int  snd_idle = 28;
  int  rcv_idle = 55;
  int  n_errors = 0;
  int  stall_cycles = 0;
  int  n_queued = 0;
  bit  in_taken = 1'b0;

  histogram_equalizer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_pixel_value(in_pixel_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_pixel(out_pixel),
    .out_lowest_count(out_lowest_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned eff_side(logic [histeq_pkg::REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return v;
  endfunction

  function automatic logic [7:0] equalize(logic [7:0] p);
    longint unsigned c, diff, area, q;
    c = cdf_table[p];
    diff = (c > first_cdf) ? c - first_cdf : 0;
    area = eff_side(img_w) * eff_side(img_h);
    q = (2 * diff * (NUM_LEVELS - 1) + area) / (2 * area);
    if (q > NUM_LEVELS - 1) q = NUM_LEVELS - 1;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  task automatic predict_op(pixel_op_t op);
    longint unsigned sum;
    bit found;
    logic [histeq_pkg::CNT_W-1:0] lo;
    eq_result_t r;
    sum = 0;
    found = 1'b0;
    lo = '0;
    case (op.act)
      histeq_pkg::ACT_COUNT:
        if (cdf_table[op.pix] != histeq_pkg::CNT_MAX) cdf_table[op.pix]++;
      histeq_pkg::ACT_FINALIZE: begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
          if (!found && cdf_table[i] != 0) begin
            found = 1'b1;
            lo = cdf_table[i];
          end
          sum += cdf_table[i];
          if (sum > histeq_pkg::CNT_MAX) sum = histeq_pkg::CNT_MAX;
          cdf_table[i] = sum[histeq_pkg::CNT_W-1:0];
        end
        first_cdf = lo;
        r = '{kind: histeq_pkg::KIND_FIN, pix: 8'd0, low: first_cdf};
        result_q.push_back(r);
      end
      histeq_pkg::ACT_MAP: begin
        r = '{kind: histeq_pkg::KIND_MAP, pix: equalize(op.pix), low: '0};
        result_q.push_back(r);
      end
      default: begin
        foreach (cdf_table[i]) cdf_table[i] = '0;
        first_cdf = '0;
      end
    endcase
  endtask

  // driver: new transaction only once the previous one is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (op_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          pixel_op_t op;
          op = op_q.pop_front();
          in_valid <= 1'b1;
          in_action <= op.act;
          in_pixel_value <= op.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    bit any_fire;
    eq_result_t e;
    any_fire = 1'b0;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_op('{act: histeq_pkg::action_t'(in_action), pix: in_pixel_value});
        any_fire = 1'b1;
      end
      if (out_valid && out_ready) begin
        any_fire = 1'b1;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d pix=%0d low=%0d", $time,
                   out_result_kind, out_pixel, out_lowest_count);
          n_errors++;
        end else begin
          e = result_q.pop_front();
          if (out_result_kind !== e.kind) begin
            $display("%0t: result_kind exp %0d act %0d", $time, e.kind, out_result_kind);
            n_errors++;
          end
          if (out_pixel !== e.pix) begin
            $display("%0t: out_pixel exp %0d act %0d", $time, e.pix, out_pixel);
            n_errors++;
          end
          if (out_lowest_count !== e.low) begin
            $display("%0t: lowest_count exp %0d act %0d", $time, e.low, out_lowest_count);
            n_errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) any_fire = 1'b1;
      stall_cycles = any_fire ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("%0t: watchdog expired", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_op(histeq_pkg::action_t a, logic [7:0] p);
    op_q.push_back('{act: a, pix: p});
    n_queued++;
  endtask

  task automatic wait_drained();
    while (op_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [histeq_pkg::CFG_IDX_W-1:0] idx,
                           logic [histeq_pkg::REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == histeq_pkg::REG_WIDTH) img_w = val;
    else if (idx == histeq_pkg::REG_HEIGHT) img_h = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frame(int n_count, int n_map, bit narrow);
    int base;
    base = $urandom_range(255);
    if ($urandom_range(9) != 0) push_op(histeq_pkg::ACT_CLEAR, 8'($urandom));
    for (int i = 0; i < n_count; i++)
      push_op(histeq_pkg::ACT_COUNT,
              narrow ? 8'(base + $urandom_range(7)) : 8'($urandom));
    push_op(histeq_pkg::ACT_FINALIZE, 8'($urandom));
    for (int i = 0; i < n_map; i++) begin
      if ($urandom_range(19) == 0)
        push_op(histeq_pkg::action_t'($urandom_range(3)), 8'($urandom));
      else
        push_op(histeq_pkg::ACT_MAP,
                narrow ? 8'(base + $urandom_range(9) - 1) : 8'($urandom));
    end
  endtask

  initial begin
    logic [histeq_pkg::REG_W-1:0] sizes[6];
    sizes = '{13'd0, 13'd1, 13'd4096, 13'd4097, 13'd8191, 13'd256};
    foreach (cdf_table[i]) cdf_table[i] = '0;
    first_cdf = '0;
    img_w = histeq_pkg::REG_W'(histeq_pkg::SIDE_RESET);
    img_h = histeq_pkg::REG_W'(histeq_pkg::SIDE_RESET);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // map before finalize, empty finalize, level at the lowest, repeated finalize
    push_op(histeq_pkg::ACT_MAP, 8'd0);
    push_op(histeq_pkg::ACT_FINALIZE, 8'hff);
    for (int i = 0; i < 3; i++) push_op(histeq_pkg::ACT_COUNT, 8'd10);
    push_op(histeq_pkg::ACT_COUNT, 8'd255);
    push_op(histeq_pkg::ACT_COUNT, 8'd0);
    push_op(histeq_pkg::ACT_COUNT, 8'd128);
    push_op(histeq_pkg::ACT_MAP, 8'd255);
    push_op(histeq_pkg::ACT_FINALIZE, 8'h00);
    push_op(histeq_pkg::ACT_MAP, 8'd0);
    push_op(histeq_pkg::ACT_MAP, 8'd5);
    push_op(histeq_pkg::ACT_MAP, 8'd10);
    push_op(histeq_pkg::ACT_MAP, 8'd128);
    push_op(histeq_pkg::ACT_MAP, 8'd255);
    push_op(histeq_pkg::ACT_FINALIZE, 8'h55);
    push_op(histeq_pkg::ACT_MAP, 8'd200);
    push_op(histeq_pkg::ACT_CLEAR, 8'haa);
    push_op(histeq_pkg::ACT_MAP, 8'd255);
    push_op(histeq_pkg::ACT_FINALIZE, 8'h00);
    wait_drained();

    // unit area pushes results to the top; stacked finalizes saturate the sums
    write_reg(histeq_pkg::REG_WIDTH, 13'd1);
    write_reg(histeq_pkg::REG_HEIGHT, 13'd1);
    write_reg(2'd2, 13'h1fff);
    write_reg(2'd3, 13'h0aaa);
    push_op(histeq_pkg::ACT_CLEAR, 8'd0);
    for (int i = 0; i < NUM_LEVELS; i++) push_op(histeq_pkg::ACT_COUNT, 8'(i));
    for (int k = 0; k < 6; k++) begin
      push_op(histeq_pkg::ACT_FINALIZE, 8'd0);
      push_op(histeq_pkg::ACT_MAP, 8'($urandom));
      push_op(histeq_pkg::ACT_MAP, 8'd255);
    end
    push_op(histeq_pkg::ACT_COUNT, 8'd255);
    push_op(histeq_pkg::ACT_MAP, 8'd255);
    wait_drained();

    while (n_queued < ITEM_GOAL) begin
      if (n_queued > ITEM_GOAL / 3 && snd_idle == 28) begin
        snd_idle = 55;
        rcv_idle = 28;
      end else if (n_queued > 2 * ITEM_GOAL / 3 && snd_idle == 55) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if ($urandom_range(4) == 0) begin
        write_reg(histeq_pkg::REG_WIDTH, sizes[$urandom_range(5)]);
        write_reg(histeq_pkg::REG_HEIGHT, sizes[$urandom_range(5)]);
      end else begin
        write_reg(histeq_pkg::REG_WIDTH, histeq_pkg::REG_W'($urandom_range(1, 12)));
        write_reg(histeq_pkg::REG_HEIGHT, histeq_pkg::REG_W'($urandom_range(1, 12)));
      end
      if ($urandom_range(3) == 0)
        write_reg(histeq_pkg::CFG_IDX_W'($urandom_range(2, 3)),
                  histeq_pkg::REG_W'($urandom));
      for (int f = 0; f < 3; f++)
        run_frame($urandom_range(1, 60), $urandom_range(5, 30), 1'($urandom_range(1)));
      wait_drained();
    end

    wait_drained();
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
